FILE: design/glc_pkg.sv
package glc_pkg;

  localparam int CODE_W = 8;
  localparam int FONT_W = 4;
  localparam int SIZE_W = 8;
  localparam int NUM_CODES = 256;

  localparam logic [1:0] ST_HIT     = 2'd0;
  localparam logic [1:0] ST_FILL    = 2'd1;
  localparam logic [1:0] ST_NO_FONT = 2'd2;
  localparam logic [1:0] ST_FAIL    = 2'd3;

  localparam logic REG_FONT_MASK = 1'b0;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic [FONT_W-1:0] font;
    logic [SIZE_W-1:0] size;
  } tag_t;

  typedef struct packed {
    logic  en_move;
    logic  en_insert;
    logic  shift_all;
    code_t code;
  } chain_ctl_t;

endpackage

FILE: design/glc_cell.sv
module glc_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  glc_pkg::chain_ctl_t ctl,
  input  logic                found_in,
  input  logic                prev_occ,
  input  logic                next_occ,
  input  glc_pkg::code_t      next_code,
  output logic                found_out,
  output logic                occ,
  output glc_pkg::code_t      code
);

  logic           occ_r;
  logic           occ_nxt;
  glc_pkg::code_t code_r;
  glc_pkg::code_t code_nxt;
  logic           match;
  logic           shift;
  logic           load;

  assign match     = occ_r && (code_r == ctl.code);
  assign found_out = found_in | match;
  assign shift     = occ_r && ((ctl.en_move && found_out) || (ctl.en_insert && ctl.shift_all));
  assign load      = !occ_r && ctl.en_insert && !ctl.shift_all && prev_occ;

  always_comb begin
    occ_nxt  = occ_r;
    code_nxt = code_r;
    if (shift) begin
      code_nxt = next_occ ? next_code : ctl.code;
    end else if (load) begin
      code_nxt = ctl.code;
      occ_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign occ  = occ_r;
  assign code = code_r;

endmodule

FILE: design/glc_chain.sv
module glc_chain #(
  parameter int CAPACITY = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  glc_pkg::chain_ctl_t ctl,
  output logic                full,
  output logic                found,
  output logic                head_occ,
  output glc_pkg::code_t      head_code
);

  logic                 found_c [CAPACITY+1];
  logic                 occ_c   [CAPACITY];
  glc_pkg::code_t       code_c  [CAPACITY];

  assign found_c[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic           prev_occ;
    logic           next_occ;
    glc_pkg::code_t next_code;

    if (i == 0) begin : g_head
      assign prev_occ = 1'b1;
    end else begin : g_body
      assign prev_occ = occ_c[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_occ  = 1'b0;
      assign next_code = '0;
    end else begin : g_link
      assign next_occ  = occ_c[i+1];
      assign next_code = code_c[i+1];
    end

    glc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .found_in  (found_c[i]),
      .prev_occ  (prev_occ),
      .next_occ  (next_occ),
      .next_code (next_code),
      .found_out (found_c[i+1]),
      .occ       (occ_c[i]),
      .code      (code_c[i])
    );
  end

  assign full      = occ_c[CAPACITY-1];
  assign found     = found_c[CAPACITY];
  assign head_occ  = occ_c[0];
  assign head_code = code_c[0];

endmodule

FILE: design/glyph_lru_cache_unit.sv
// Fully associative LRU glyph cache for up to CAPACITY glyphs, keyed by an
// 8-bit character code and tagged with font id and pixel size. A request
// first makes the registered read of the 256-entry tag memory, then comes to
// the execute state, in which a row of CAPACITY recency cells (slot 0 holds
// the least recently used code) compares, shifts toward the head and appends
// at the tail, while the per-character valid bit is checked. The next word is
// accepted once the result has moved into the output register; a held output
// word stretches the request by the cycles it waits. Reset clears the valid
// bits, cells and count at once, with no clearing pass. The font mask
// register sits at byte address 0.
module glyph_lru_cache_unit #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic [3:0]  in_font_id,
  input  logic [7:0]  in_pixel_size,
  input  logic        in_fetch_ok,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_retagged,
  output logic        out_evicted_valid,
  output logic [7:0]  out_evicted_char,
  output logic [5:0]  out_occupancy,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;
  localparam logic REG_FONT_MASK_BIT = glc_pkg::REG_FONT_MASK;

  logic                      state_r;
  logic                      state_nxt;
  logic [15:0]               font_mask_r;
  glc_pkg::code_t            code_r;
  logic [glc_pkg::FONT_W-1:0] font_r;
  logic [glc_pkg::SIZE_W-1:0] size_r;
  logic                      fetch_r;
  glc_pkg::tag_t             tag_mem [glc_pkg::NUM_CODES];
  glc_pkg::tag_t             tag_rd_r;
  logic [glc_pkg::NUM_CODES-1:0] valid_r;
  logic [glc_pkg::NUM_CODES-1:0] valid_nxt;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;

  logic                      in_accept;
  logic                      exec_go;
  logic                      font_ok;
  logic                      valid_at;
  logic                      hit;
  logic                      do_fill;
  logic                      evict;
  logic [1:0]                status;
  glc_pkg::chain_ctl_t       ctl;
  logic                      full;
  logic                      found;
  logic                      head_occ;
  glc_pkg::code_t            head_code;
  logic [8:0]                count_ext;

  logic                      out_valid_r;
  logic [1:0]                out_status_r;
  logic                      out_retagged_r;
  logic                      out_evicted_valid_r;
  logic [7:0]                out_evicted_char_r;
  logic [5:0]                out_occupancy_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FONT_MASK_BIT) ? {16'd0, font_mask_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_mask_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_FONT_MASK_BIT) begin
      font_mask_r <= pwdata[15:0];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_accept) state_nxt = S_EXEC;
      S_EXEC: if (exec_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      code_r   <= in_char_code;
      font_r   <= in_font_id;
      size_r   <= in_pixel_size;
      fetch_r  <= in_fetch_ok;
      tag_rd_r <= tag_mem[in_char_code];
    end
  end

  always_ff @(posedge clk) begin
    if (do_fill) begin
      tag_mem[code_r] <= '{font: font_r, size: size_r};
    end
  end

  assign font_ok  = font_mask_r[font_r];
  assign valid_at = valid_r[code_r];
  assign hit      = valid_at && (tag_rd_r.font == font_r) && (tag_rd_r.size == size_r);
  assign do_fill  = exec_go && font_ok && !hit && fetch_r;
  assign evict    = do_fill && !valid_at && full;

  always_comb begin
    if (!font_ok) begin
      status = glc_pkg::ST_NO_FONT;
    end else if (hit) begin
      status = glc_pkg::ST_HIT;
    end else if (!fetch_r) begin
      status = glc_pkg::ST_FAIL;
    end else begin
      status = glc_pkg::ST_FILL;
    end
  end

  always_comb begin
    ctl.en_move   = exec_go && font_ok && valid_at && (hit || fetch_r);
    ctl.en_insert = do_fill && !valid_at;
    ctl.shift_all = full;
    ctl.code      = code_r;
  end

  glc_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .full      (full),
    .found     (found),
    .head_occ  (head_occ),
    .head_code (head_code)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (do_fill) begin
      valid_nxt[code_r] = 1'b1;
    end
    if (evict) begin
      valid_nxt[head_code] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign count_nxt = (ctl.en_insert && !full) ? count_r + CW'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count_ext = 9'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status_r        <= status;
      out_retagged_r      <= font_ok && valid_at && !hit && fetch_r;
      out_evicted_valid_r <= evict;
      out_evicted_char_r  <= evict ? head_code : 8'd0;
      out_occupancy_r     <= count_ext[5:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_retagged      = out_retagged_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_char  = out_evicted_char_r;
  assign out_occupancy     = out_occupancy_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("occupancy count above capacity");

  a_count_matches_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == !head_occ)
    else $error("occupancy count disagrees with recency cells");

  a_move_finds_code: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.en_move |-> found)
    else $error("valid character missing from recency cells");

  a_exec_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_valid_r && state_r == S_IDLE)
    else $error("result not registered after execute");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == S_EXEC)
    else $error("accepted word did not enter execute");

endmodule

FILE: sim/tb_glyph_lru_cache_unit.sv
module tb_glyph_lru_cache_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CACHE_CAP = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_LIMIT = 60;

  typedef struct packed {
    logic [1:0] status;
    logic       retagged;
    logic       ev_valid;
    logic [7:0] ev_char;
    logic [5:0] occupancy;
  } lookup_result_t;

  class glyph_lru_tracker;
    bit             cached[256];
    logic [3:0]     tag_font[256];
    logic [7:0]     tag_size[256];
    bit [7:0]       recency[$];
    bit [15:0]      font_mask;
    lookup_result_t pending_results[$];
    int             mismatch_count;

    function new();
      foreach (cached[i]) cached[i] = 1'b0;
      recency.delete();
      font_mask = '0;
      mismatch_count = 0;
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
        $display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, field, got, want);
    endtask

    function void drop_code(logic [7:0] code);
      for (int i = 0; i < recency.size(); i++) begin
        if (recency[i] == code) begin
          recency.delete(i);
          return;
        end
      end
    endfunction

    function void note_request(logic [7:0] code, logic [3:0] font, logic [7:0] size,
                               logic ok);
      lookup_result_t r;
      bit [7:0]       victim;
      r = '0;
      if (!font_mask[font]) begin
        r.status = glc_pkg::ST_NO_FONT;
      end else if (cached[code] && tag_font[code] == font && tag_size[code] == size) begin
        drop_code(code);
        recency.push_back(code);
        r.status = glc_pkg::ST_HIT;
      end else if (!ok) begin
        r.status = glc_pkg::ST_FAIL;
      end else begin
        if (cached[code]) begin
          drop_code(code);
          r.retagged = 1'b1;
        end
        cached[code] = 1'b1;
        tag_font[code] = font;
        tag_size[code] = size;
        recency.push_back(code);
        if (recency.size() > CACHE_CAP) begin
          victim = recency.pop_front();
          cached[victim] = 1'b0;
          r.ev_valid = 1'b1;
          r.ev_char = victim;
        end
        r.status = glc_pkg::ST_FILL;
      end
      r.occupancy = 6'(recency.size());
      pending_results.push_back(r);
    endfunction

    task check_result(lookup_result_t got);
      lookup_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 32'(got), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.retagged !== want.retagged)
          report_mismatch("retagged", 32'(got.retagged), 32'(want.retagged));
        if (got.ev_valid !== want.ev_valid)
          report_mismatch("evicted_valid", 32'(got.ev_valid), 32'(want.ev_valid));
        if (got.ev_char !== want.ev_char)
          report_mismatch("evicted_char", 32'(got.ev_char), 32'(want.ev_char));
        if (got.occupancy !== want.occupancy)
          report_mismatch("occupancy", 32'(got.occupancy), 32'(want.occupancy));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = '0;
  logic [3:0]  in_font_id = '0;
  logic [7:0]  in_pixel_size = '0;
  logic        in_fetch_ok = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_retagged;
  logic        out_evicted_valid;
  logic [7:0]  out_evicted_char;
  logic [5:0]  out_occupancy;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  glyph_lru_tracker sb;
  int               cycle_count = 0;
  int               stall_left = 0;
  int               run_left = 0;
  logic [3:0]       home_font[256];
  logic [7:0]       home_size[256];

  glyph_lru_cache_unit #(.CAPACITY(CACHE_CAP)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_font_id       (in_font_id),
    .in_pixel_size    (in_pixel_size),
    .in_fetch_ok      (in_fetch_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_retagged     (out_retagged),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_char (out_evicted_char),
    .out_occupancy    (out_occupancy),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // hold off the result side in runs of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      out_stall <= 1'b0;
      run_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 99) < 15)
        run_left = $urandom_range(20, 80);
      else
        run_left = $urandom_range(0, 6);
      if ($urandom_range(0, 99) < 6)
        stall_left = $urandom_range(10, 40);
      else
        stall_left = $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_status, out_retagged, out_evicted_valid, out_evicted_char,
                       out_occupancy});
  end

  task automatic send_word(logic [7:0] code, logic [3:0] font, logic [7:0] size,
                           logic ok, bit no_gap);
    int gap;
    int r;
    in_valid <= 1'b1;
    in_char_code <= code;
    in_font_id <= font;
    in_pixel_size <= size;
    in_fetch_ok <= ok;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    sb.note_request(code, font, size, ok);
    r = $urandom_range(0, 99);
    if (no_gap || r < 50) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 8);
    else gap = $urandom_range(15, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_access(logic wr, logic [15:0] data, output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {glc_pkg::REG_FONT_MASK, 2'b00};
    pwdata <= {16'h0, data};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_font_mask(logic [15:0] mask);
    logic [31:0] rd;
    cfg_access(1'b1, mask, rd);
    sb.font_mask = mask;
    cfg_access(1'b0, 16'h0, rd);
    if (rd[15:0] !== mask)
      sb.report_mismatch("font mask readback", rd, 32'(mask));
  endtask

  task automatic run_phase(logic [15:0] mask, int count);
    int         base;
    int         width;
    int         burst_left;
    int         r;
    logic [7:0] code;
    logic [3:0] font;
    logic [7:0] size;
    logic       ok;
    set_font_mask(mask);
    for (int c = 0; c < 256; c++) begin
      font = 4'($urandom_range(0, 15));
      if (mask != 0)
        while (!mask[font]) font = 4'($urandom_range(0, 15));
      home_font[c] = font;
      home_size[c] = 8'($urandom_range(0, 255));
    end
    base = $urandom_range(0, 255);
    width = $urandom_range(20, 60);
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 59) == 0) begin
        base = $urandom_range(0, 255);
        width = $urandom_range(8, 70);
      end
      if (burst_left > 0) burst_left--;
      else if ($urandom_range(0, 99) < 3) burst_left = $urandom_range(20, 40);
      code = 8'(base + $urandom_range(0, width - 1));
      font = home_font[code];
      size = home_size[code];
      r = $urandom_range(0, 99);
      if (r >= 92) begin
        code = 8'($urandom_range(0, 255));
        font = 4'($urandom_range(0, 15));
        size = 8'($urandom_range(0, 255));
      end else if (r >= 86) begin
        size = 8'($urandom_range(0, 255));
      end else if (r >= 80) begin
        font = 4'($urandom_range(0, 15));
      end
      ok = ($urandom_range(0, 99) < 85);
      send_word(code, font, size, ok, burst_left > 0);
    end
    drain();
  endtask

  initial begin
    logic [15:0] masks[8];
    int          counts[8];
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(8'h00, 4'h0, 8'h00, 1'b1, 1'b0);
    drain();
    set_font_mask(16'hFFFF);
    send_word(8'hFF, 4'hF, 8'hFF, 1'b0, 1'b0);
    send_word(8'hFF, 4'hF, 8'hFF, 1'b1, 1'b0);
    send_word(8'hFF, 4'hF, 8'hFF, 1'b0, 1'b0);
    send_word(8'hFF, 4'hF, 8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 4'h0, 8'h00, 1'b1, 1'b0);
    send_word(8'h00, 4'h0, 8'h00, 1'b1, 1'b0);
    send_word(8'h00, 4'h0, 8'h00, 1'b1, 1'b0);
    send_word(8'hAA, 4'hA, 8'h55, 1'b1, 1'b0);
    send_word(8'h55, 4'h5, 8'hAA, 1'b0, 1'b0);
    drain();
    set_font_mask(16'h0001);
    send_word(8'h00, 4'h0, 8'h00, 1'b0, 1'b0);
    send_word(8'hFF, 4'h1, 8'h00, 1'b1, 1'b0);
    send_word(8'hAA, 4'hA, 8'h55, 1'b1, 1'b0);
    drain();

    masks = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF, 16'h0001,
              16'h0000, 16'hFFFF};
    counts = '{40, 190, 190, 180, 190, 180, 190, 180};
    masks[2] = 16'($urandom_range(1, 65535));
    masks[6] = 16'($urandom_range(1, 65535));
    for (int p = 0; p < 8; p++)
      run_phase(masks[p], counts[p]);

    repeat (20) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
